>>> hdl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: 3x3 matrix inverse types and constants
// Entry format, internal widths and the item structs of both channels.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int EW  = 32;            // entry width
  localparam int FB  = 16;            // fraction bits
  localparam int CW  = 2 * EW + 1;    // cofactor width (signed)
  localparam int HB  = EW + 1;        // low slice of a cofactor in the det product
  localparam int DW  = 3 * EW + 2;    // determinant width (signed)
  localparam int QW  = EW + 1;        // quotient bits kept by the divider
  localparam int RW  = DW + QW + 3;   // divider remainder width
  localparam int NSH = 2 * FB + 1;    // numerator shift: 2^(2*FB) scale and x2 for rounding
  localparam int NST = QW + 10;       // pipeline depth in cycles

  typedef struct packed {
    logic signed [EW-1:0] m00;
    logic signed [EW-1:0] m01;
    logic signed [EW-1:0] m02;
    logic signed [EW-1:0] m10;
    logic signed [EW-1:0] m11;
    logic signed [EW-1:0] m12;
    logic signed [EW-1:0] m20;
    logic signed [EW-1:0] m21;
    logic signed [EW-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [EW-1:0] inv00;
    logic signed [EW-1:0] inv01;
    logic signed [EW-1:0] inv02;
    logic signed [EW-1:0] inv10;
    logic signed [EW-1:0] inv11;
    logic signed [EW-1:0] inv12;
    logic signed [EW-1:0] inv20;
    logic signed [EW-1:0] inv21;
    logic signed [EW-1:0] inv22;
    logic                 singular;
    logic                 saturated;
  } out_item_t;

endpackage

>>> hdl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse: pipelined 3x3 inverse by adjugate, Q16.16
// Cofactors, determinant, then a restoring divider per entry, one bit a stage.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and pulse start; the item is taken at every edge where start
//   is high. busy stays low: a new matrix can enter in every cycle.
//   After an item is taken, out_valid is high for one cycle with
//   out_item holding the inverse, the singular flag and the saturated flag.
//   Throughput is one item per cycle. The pipeline holds the 33 quotient
//   stages of the divider plus ten stages of products, cofactors,
//   determinant and rounding/saturation.
//   A singular matrix gives all-zero entries with singular set.
//   Reset clears the valid bits of every stage; items in flight are dropped.
//   The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module matrix3x3_inverse
  import mi3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [QW-1:0] MAXP = QW'((64'd1 << (EW - 1)) - 64'd1);
  localparam logic [QW-1:0] MINM = QW'(64'd1 << (EW - 1));

  logic [NST-1:0] vld_r;
  logic           take;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], take};
    end
  end

  // Stage 1: capture
  logic signed [EW-1:0] a_r [9];

  always_ff @(posedge clk) begin
    a_r[0] <= in_item.m00;
    a_r[1] <= in_item.m01;
    a_r[2] <= in_item.m02;
    a_r[3] <= in_item.m10;
    a_r[4] <= in_item.m11;
    a_r[5] <= in_item.m12;
    a_r[6] <= in_item.m20;
    a_r[7] <= in_item.m21;
    a_r[8] <= in_item.m22;
  end

  // Stage 2: cofactor products; Stage 3: cofactors
  logic signed [2*EW-1:0] pa_r [9];
  logic signed [2*EW-1:0] pb_r [9];
  logic signed [CW-1:0]   cof_r [9];
  logic signed [EW-1:0]   a2_r [3];
  logic signed [EW-1:0]   a3_r [3];

  for (genvar j = 0; j < 9; j++) begin : g_cof
    localparam int R   = j / 3;
    localparam int C   = j % 3;
    localparam int I11 = ((R + 1) % 3) * 3 + (C + 1) % 3;
    localparam int I22 = ((R + 2) % 3) * 3 + (C + 2) % 3;
    localparam int I12 = ((R + 1) % 3) * 3 + (C + 2) % 3;
    localparam int I21 = ((R + 2) % 3) * 3 + (C + 1) % 3;
    always_ff @(posedge clk) begin
      pa_r[j]  <= a_r[I11] * a_r[I22];
      pb_r[j]  <= a_r[I12] * a_r[I21];
      cof_r[j] <= CW'(pa_r[j]) - CW'(pb_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      a2_r[c] <= a_r[c];
      a3_r[c] <= a2_r[c];
    end
  end

  // Stage 4: split det products, cofactor magnitudes and signs
  logic signed [EW+HB:0]  plo_r [3];
  logic signed [2*EW-1:0] phi_r [3];
  logic [CW-1:0]          cmag4_r [9];
  logic [CW-1:0]          cmag5_r [9];
  logic [CW-1:0]          cmag6_r [9];
  logic [CW-1:0]          cmag7_r [9];
  logic [8:0]             csg4_r, csg5_r, csg6_r, csg7_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      plo_r[c] <= a3_r[c] * $signed({1'b0, cof_r[c][HB-1:0]});
      phi_r[c] <= a3_r[c] * $signed(cof_r[c][CW-1:HB]);
    end
    for (int j = 0; j < 9; j++) begin
      cmag4_r[j] <= cof_r[j][CW-1] ? $unsigned(-cof_r[j]) : $unsigned(cof_r[j]);
      csg4_r[j]  <= cof_r[j][CW-1];
      cmag5_r[j] <= cmag4_r[j];
      cmag6_r[j] <= cmag5_r[j];
      cmag7_r[j] <= cmag6_r[j];
    end
    csg5_r <= csg4_r;
    csg6_r <= csg5_r;
    csg7_r <= csg6_r;
  end

  // Stage 5: det terms; Stage 6: det; Stage 7: magnitude and flags
  logic signed [DW-1:0] term_r [3];
  logic signed [DW-1:0] det_r;
  logic [DW-1:0]        adet_r;
  logic                 dsg_r, dz7_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      term_r[c] <= DW'(plo_r[c]) + (DW'(phi_r[c]) <<< HB);
    end
    det_r  <= term_r[0] + term_r[1] + term_r[2];
    adet_r <= det_r[DW-1] ? $unsigned(-det_r) : $unsigned(det_r);
    dsg_r  <= det_r[DW-1];
    dz7_r  <= (det_r == '0);
  end

  // Stage 8: numerators (transposed cofactors) and rounding denominator
  logic [RW-1:0] num_r [9];
  logic [RW-1:0] den8_r;
  logic [8:0]    neg8_r;
  logic          dz8_r;

  for (genvar e = 0; e < 9; e++) begin : g_num
    localparam int SRC = (e % 3) * 3 + e / 3;
    always_ff @(posedge clk) begin
      num_r[e]  <= (RW'(cmag7_r[SRC]) << NSH) + RW'(adet_r);
      neg8_r[e] <= csg7_r[SRC] ^ dsg_r;
    end
  end

  always_ff @(posedge clk) begin
    den8_r <= RW'(adet_r) << 1;
    dz8_r  <= dz7_r;
  end

  // Stage 9: overflow check; divider state index 0
  logic [RW-1:0] dv_rem_r [QW+1][9];
  logic [QW-1:0] dv_q_r   [QW+1][9];
  logic [RW-1:0] dv_den_r [QW+1];
  logic [8:0]    dv_ovf_r [QW+1];
  logic [8:0]    dv_neg_r [QW+1];
  logic          dv_dz_r  [QW+1];

  always_ff @(posedge clk) begin
    for (int e = 0; e < 9; e++) begin
      dv_rem_r[0][e] <= num_r[e];
      dv_q_r[0][e]   <= '0;
      dv_ovf_r[0][e] <= (num_r[e] >= (den8_r << QW));
    end
    dv_den_r[0] <= den8_r;
    dv_neg_r[0] <= neg8_r;
    dv_dz_r[0]  <= dz8_r;
  end

  // Stages 10..9+QW: one quotient bit per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_nxt [9];
    logic [QW-1:0] q_nxt   [9];

    always_comb begin
      dsh = dv_den_r[s] << K;
      for (int e = 0; e < 9; e++) begin
        rem_nxt[e] = dv_rem_r[s][e];
        q_nxt[e]   = dv_q_r[s][e];
        if (dv_rem_r[s][e] >= dsh) begin
          rem_nxt[e]  = dv_rem_r[s][e] - dsh;
          q_nxt[e][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      for (int e = 0; e < 9; e++) begin
        dv_rem_r[s+1][e] <= rem_nxt[e];
        dv_q_r[s+1][e]   <= q_nxt[e];
      end
      dv_den_r[s+1] <= dv_den_r[s];
      dv_ovf_r[s+1] <= dv_ovf_r[s];
      dv_neg_r[s+1] <= dv_neg_r[s];
      dv_dz_r[s+1]  <= dv_dz_r[s];
    end
  end

  // Last stage: sign, saturation, singular override
  logic [EW-1:0] res_nxt [9];
  logic [8:0]    sat_nxt;
  out_item_t     out_r;

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      if (dv_neg_r[QW][e]) begin
        sat_nxt[e] = dv_ovf_r[QW][e] || (dv_q_r[QW][e] > MINM);
        res_nxt[e] = sat_nxt[e] ? MINM[EW-1:0] : (-dv_q_r[QW][e][EW-1:0]);
      end else begin
        sat_nxt[e] = dv_ovf_r[QW][e] || (dv_q_r[QW][e] > MAXP);
        res_nxt[e] = sat_nxt[e] ? MAXP[EW-1:0] : dv_q_r[QW][e][EW-1:0];
      end
      if (dv_dz_r[QW]) begin
        sat_nxt[e] = 1'b0;
        res_nxt[e] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r.inv00     <= res_nxt[0];
    out_r.inv01     <= res_nxt[1];
    out_r.inv02     <= res_nxt[2];
    out_r.inv10     <= res_nxt[3];
    out_r.inv11     <= res_nxt[4];
    out_r.inv12     <= res_nxt[5];
    out_r.inv20     <= res_nxt[6];
    out_r.inv21     <= res_nxt[7];
    out_r.inv22     <= res_nxt[8];
    out_r.singular  <= dv_dz_r[QW];
    out_r.saturated <= |sat_nxt;
  end

  assign out_valid = vld_r[NST-1];
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  a_out_follows_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, NST))
    else $error("result strobe without an item taken");

  a_singular_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.singular |-> !out_item.saturated)
    else $error("singular result flagged saturated");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.singular |-> out_item.inv00 == '0 && out_item.inv22 == '0)
    else $error("singular result has nonzero entries");
`endif

endmodule

>>> tb/sv/matrix3x3_inverse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_checker: inverse predictor and result comparator
// Watches the item and result channels, computes each expected inverse with
// wide exact arithmetic, and compares every result field in order.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_checker
  import mi3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  out_item_t inverse_q[$];

  function automatic out_item_t invert(in_item_t mi);
    logic signed [255:0] a[3][3];
    logic signed [255:0] cof[3][3];
    logic signed [255:0] det, adet, n, q;
    logic signed [255:0] maxpos, minmag;
    logic [EW-1:0]       ent[9];
    logic                neg, sat;
    out_item_t           res;
    a[0][0] = mi.m00; a[0][1] = mi.m01; a[0][2] = mi.m02;
    a[1][0] = mi.m10; a[1][1] = mi.m11; a[1][2] = mi.m12;
    a[2][0] = mi.m20; a[2][1] = mi.m21; a[2][2] = mi.m22;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                  - a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
    det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    adet   = det < 0 ? -det : det;
    maxpos = (256'sd1 <<< (EW-1)) - 1;
    minmag = 256'sd1 <<< (EW-1);
    sat    = 1'b0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        n   = cof[c][r] <<< (2*FB);
        neg = (n < 0) != (det < 0);
        if (n < 0) n = -n;
        // round half away from zero on magnitudes
        q = ((n <<< 1) + adet) / (adet <<< 1);
        if (q == 0) neg = 1'b0;
        if (!neg && q > maxpos) begin q = maxpos; sat = 1'b1; end
        if (neg && q > minmag) begin q = minmag; sat = 1'b1; end
        if (neg) q = -q;
        ent[r*3+c] = q[EW-1:0];
      end
    res.inv00 = ent[0]; res.inv01 = ent[1]; res.inv02 = ent[2];
    res.inv10 = ent[3]; res.inv11 = ent[4]; res.inv12 = ent[5];
    res.inv20 = ent[6]; res.inv21 = ent[7]; res.inv22 = ent[8];
    res.saturated = sat;
    return res;
  endfunction

  assign pending = inverse_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      inverse_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (inverse_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = inverse_q.pop_front();
          if (want !== out_item) begin
            $display("%0t mismatch expected %h actual %h", $time, want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) inverse_q.push_back(invert(in_item));
    end
  end

endmodule

>>> tb/sv/matrix3x3_inverse_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_test: testbench top for the 3x3 matrix inverse
// Drives directed and random matrices under varying idle rates and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_test;
  import mi3_pkg::*;

  localparam int LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[matrix3x3_inverse] ERROR");
      $finish;
    end
  end

  matrix3x3_inverse DUT (.*);

  matrix3x3_inverse_checker u_checker (.*);

  function automatic logic [EW-1:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      3: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      4: return $urandom_range(0, 3);
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // present one matrix and hold it until taken; idle_pct gaps before it
  task automatic send_matrix(in_item_t mi, int idle_pct);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= mi;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic in_item_t diag(logic [EW-1:0] d0, logic [EW-1:0] d1,
                                    logic [EW-1:0] d2);
    in_item_t mi;
    mi = '0;
    mi.m00 = d0; mi.m11 = d1; mi.m22 = d2;
    return mi;
  endfunction

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t mi;
    int       idle;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, zero, scaled, singular rows, extremes, tiny determinant
    send_matrix(diag(32'h1_0000, 32'h1_0000, 32'h1_0000), 0);
    send_matrix('0, 0);
    send_matrix(diag(32'h2_0000, 32'hffff_0000, 32'h0_8000), 0);
    send_matrix(diag(32'd1, 32'd1, 32'd1), 0);
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
    send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0);
    send_matrix(diag(32'h8000_0000, 32'd1, 32'h7fff_ffff), 0);
    send_matrix(diag(32'd3, 32'hffff_fffd, 32'd7), 0);
    send_matrix({9{32'h1_0000}}, 0);
    send_matrix({9{32'h8000_0000}}, 0);
    send_matrix({9{32'hffff_ffff}}, 0);
    mi = {32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h5_0000,
          32'h6_0000, 32'h7_0000, 32'h8_0000, 32'ha_0000};
    send_matrix(mi, 0);
    mi = {32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h1_0000,
          32'h1_0000, 32'h0, 32'h0};
    send_matrix(mi, 0);
    mi = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1};
    send_matrix(mi, 0);
    // pause until every expected result is back
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle = (ph == 1) ? 86 : (ph == 3) ? 18 : 0;
      for (int i = 0; i < 335; i++) begin
        for (int k = 0; k < 9; k++) mi[k*EW +: EW] = rand_entry();
        // copy a row into another to force some singular matrices
        if ($urandom_range(0, 9) == 0) mi[EW*6 +: EW*3] = mi[0 +: EW*3];
        send_matrix(mi, idle);
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("[matrix3x3_inverse] OK");
    else $display("[matrix3x3_inverse] ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/mi3_pkg.sv
hdl/matrix3x3_inverse.sv
tb/sv/matrix3x3_inverse_checker.sv
tb/sv/matrix3x3_inverse_test.sv
